### design/aabb_pkg.sv
// Shared types and constants for the all-pairs box overlap core.
package aabb_pkg;

    localparam int MAX_BOXES   = 64;
    localparam int STORE_DEPTH = 64;
    localparam int COORD_W     = 32;
    localparam int IDX_W       = 6;
    localparam int COUNT_W     = 7;
    localparam int MASK_W      = 64;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef struct packed {
        logic signed [COORD_W-1:0] min_x;
        logic signed [COORD_W-1:0] min_y;
        logic signed [COORD_W-1:0] min_z;
        logic signed [COORD_W-1:0] max_x;
        logic signed [COORD_W-1:0] max_y;
        logic signed [COORD_W-1:0] max_z;
    } box_t;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
    } store_req_t;

endpackage

### design/aabb_pairwise_overlap_core.sv
// Top level of the all-pairs axis-aligned box overlap core.
//
// Each add transfer compares the new box, strictly and as signed Q16.16 on every
// axis, against all boxes stored since the last clear, then stores it and returns
// its index with a mask of the earlier boxes it overlaps. The stored boxes live in
// one memory that is read one entry per cycle, so an add into a store holding N
// boxes scans all N entries before the next input transfer can be taken; an
// accepted box is scanned against at most 63 stored boxes. A clear transfer
// returns no result. When the store is full, the box is dropped and the result
// carries rejected = 1 with a zero index and a zero mask. A finished result waits
// in the output register while the next item may be scanned, and an add or a
// rejected box cannot finish, and so holds off the input, for as long as that
// register is still occupied.
module aabb_pairwise_overlap_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_cmd,
    input  logic signed [aabb_pkg::COORD_W-1:0]   s_min_x,
    input  logic signed [aabb_pkg::COORD_W-1:0]   s_min_y,
    input  logic signed [aabb_pkg::COORD_W-1:0]   s_min_z,
    input  logic signed [aabb_pkg::COORD_W-1:0]   s_max_x,
    input  logic signed [aabb_pkg::COORD_W-1:0]   s_max_y,
    input  logic signed [aabb_pkg::COORD_W-1:0]   s_max_z,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [aabb_pkg::IDX_W-1:0]            m_box_index,
    output logic [aabb_pkg::MASK_W-1:0]           m_overlap_mask,
    output logic                                  m_rejected
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]                       state_reg, state_next;
    logic [aabb_pkg::COUNT_W-1:0]     count_reg, count_next;
    logic [aabb_pkg::IDX_W-1:0]       chk_idx_reg, chk_idx_next;
    logic [aabb_pkg::MASK_W-1:0]      mask_reg, mask_next;
    logic                             rej_reg, rej_next;
    aabb_pkg::box_t                   box_reg, box_next;

    logic                             m_valid_reg, m_valid_next;
    logic [aabb_pkg::IDX_W-1:0]       m_index_reg, m_index_next;
    logic [aabb_pkg::MASK_W-1:0]      m_mask_reg, m_mask_next;
    logic                             m_rej_reg, m_rej_next;

    aabb_pkg::store_req_t             store_req;
    aabb_pkg::box_t                   stored_box;
    aabb_pkg::box_t                   in_box;

    logic                             in_xfer;
    logic                             out_free;
    logic                             hit;
    logic                             last_entry;
    logic                             full;

    assign in_box.min_x = s_min_x;
    assign in_box.min_y = s_min_y;
    assign in_box.min_z = s_min_z;
    assign in_box.max_x = s_max_x;
    assign in_box.max_y = s_max_y;
    assign in_box.max_z = s_max_z;

    assign s_ready  = (state_reg == ST_IDLE);
    assign in_xfer  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign full     = (count_reg >= aabb_pkg::COUNT_W'(aabb_pkg::MAX_BOXES));

    assign hit = (stored_box.min_x < box_reg.max_x) && (stored_box.max_x > box_reg.min_x) &&
                 (stored_box.min_y < box_reg.max_y) && (stored_box.max_y > box_reg.min_y) &&
                 (stored_box.min_z < box_reg.max_z) && (stored_box.max_z > box_reg.min_z);

    assign last_entry = ((aabb_pkg::COUNT_W'(chk_idx_reg) + aabb_pkg::COUNT_W'(1)) == count_reg);

    aabb_box_store u_store (
        .aclk    (aclk),
        .req     (store_req),
        .wr_data (box_reg),
        .rd_data (stored_box)
    );

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        chk_idx_next = chk_idx_reg;
        mask_next    = mask_reg;
        rej_next     = rej_reg;
        box_next     = box_reg;
        m_valid_next = m_valid_reg;
        m_index_next = m_index_reg;
        m_mask_next  = m_mask_reg;
        m_rej_next   = m_rej_reg;

        store_req.wr_en   = 1'b0;
        store_req.wr_addr = count_reg[aabb_pkg::IDX_W-1:0];
        store_req.rd_en   = 1'b0;
        store_req.rd_addr = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    box_next     = in_box;
                    mask_next    = '0;
                    chk_idx_next = '0;
                    rej_next     = 1'b0;
                    if (s_cmd == aabb_pkg::CMD_CLEAR) begin
                        count_next = '0;
                    end else if (full) begin
                        rej_next   = 1'b1;
                        state_next = ST_FINISH;
                    end else if (count_reg == '0) begin
                        state_next = ST_FINISH;
                    end else begin
                        store_req.rd_en   = 1'b1;
                        store_req.rd_addr = '0;
                        state_next        = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                mask_next[chk_idx_reg] = hit;
                if (last_entry) begin
                    state_next = ST_FINISH;
                end else begin
                    store_req.rd_en   = 1'b1;
                    store_req.rd_addr = chk_idx_reg + aabb_pkg::IDX_W'(1);
                    chk_idx_next      = chk_idx_reg + aabb_pkg::IDX_W'(1);
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_rej_next   = rej_reg;
                    m_mask_next  = rej_reg ? '0 : mask_reg;
                    m_index_next = rej_reg ? '0 : count_reg[aabb_pkg::IDX_W-1:0];
                    if (!rej_reg) begin
                        store_req.wr_en = 1'b1;
                        count_next      = count_reg + aabb_pkg::COUNT_W'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        chk_idx_reg <= chk_idx_next;
        mask_reg    <= mask_next;
        rej_reg     <= rej_next;
        box_reg     <= box_next;
        m_index_reg <= m_index_next;
        m_mask_reg  <= m_mask_next;
        m_rej_reg   <= m_rej_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_box_index    = m_index_reg;
    assign m_overlap_mask = m_mask_reg;
    assign m_rejected     = m_rej_reg;

    // The scan never reads past the boxes that are stored.
    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (aabb_pkg::COUNT_W'(chk_idx_reg) < count_reg))
        else $error("scan index beyond stored box count");

    // The store never holds more boxes than it may.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= aabb_pkg::COUNT_W'(aabb_pkg::MAX_BOXES))
        else $error("box count exceeds capacity");

    // A clear transfer empties the store.
    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && (s_cmd == aabb_pkg::CMD_CLEAR)) |=> (count_reg == '0))
        else $error("clear did not empty the store");

    // A stored box advances the count by exactly one.
    a_write_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        store_req.wr_en |=> (count_reg == $past(count_reg) + aabb_pkg::COUNT_W'(1)))
        else $error("box write did not advance the count");

    // A rejected result is only produced when the store was full.
    a_reject_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && rej_reg) |-> full)
        else $error("box rejected while store had room");

endmodule

### design/aabb_box_store.sv
// Box corner memory: one write port and one read port with registered read data.
module aabb_box_store (
    input  logic                aclk,
    input  aabb_pkg::store_req_t req,
    input  aabb_pkg::box_t       wr_data,
    output aabb_pkg::box_t       rd_data
);

    aabb_pkg::box_t mem [aabb_pkg::STORE_DEPTH];
    aabb_pkg::box_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### tb/aabb_pairwise_overlap_core_test.sv
// Self-checking testbench for the all-pairs axis-aligned box overlap core.
module aabb_pairwise_overlap_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam real CLK_PERIOD      = 4.0;
    localparam int  RESET_CYCLES    = 8;
    localparam int  TARGET_ITEMS    = 1500;
    localparam int  HOLD_OFF_CYCLES = 600;
    localparam int  HOLD_OFF_AT     = 150;
    localparam int  DRAIN_CYCLES    = 80;
    localparam int  WATCHDOG_LIMIT  = 4000;
    localparam int  Q_ONE           = 65536;

    typedef struct packed {
        logic           cmd;
        aabb_pkg::box_t box;
    } box_item_t;

    typedef struct packed {
        logic [aabb_pkg::IDX_W-1:0]  box_index;
        logic [aabb_pkg::MASK_W-1:0] overlap_mask;
        logic                        rejected;
    } overlap_result_t;

    logic                                aclk = 1'b0;
    logic                                aresetn = 1'b0;
    logic                                s_valid = 1'b0;
    logic                                s_ready;
    logic                                s_cmd = aabb_pkg::CMD_ADD;
    logic signed [aabb_pkg::COORD_W-1:0] s_min_x = '0;
    logic signed [aabb_pkg::COORD_W-1:0] s_min_y = '0;
    logic signed [aabb_pkg::COORD_W-1:0] s_min_z = '0;
    logic signed [aabb_pkg::COORD_W-1:0] s_max_x = '0;
    logic signed [aabb_pkg::COORD_W-1:0] s_max_y = '0;
    logic signed [aabb_pkg::COORD_W-1:0] s_max_z = '0;
    logic                                m_valid;
    logic                                m_ready = 1'b0;
    logic [aabb_pkg::IDX_W-1:0]          m_box_index;
    logic [aabb_pkg::MASK_W-1:0]         m_overlap_mask;
    logic                                m_rejected;

    box_item_t       boxes_to_send[$];
    overlap_result_t expected_overlaps[$];

    logic signed [aabb_pkg::COORD_W-1:0] lower_x[aabb_pkg::STORE_DEPTH];
    logic signed [aabb_pkg::COORD_W-1:0] lower_y[aabb_pkg::STORE_DEPTH];
    logic signed [aabb_pkg::COORD_W-1:0] lower_z[aabb_pkg::STORE_DEPTH];
    logic signed [aabb_pkg::COORD_W-1:0] upper_x[aabb_pkg::STORE_DEPTH];
    logic signed [aabb_pkg::COORD_W-1:0] upper_y[aabb_pkg::STORE_DEPTH];
    logic signed [aabb_pkg::COORD_W-1:0] upper_z[aabb_pkg::STORE_DEPTH];
    int stored_boxes = 0;

    int total_items = 0;
    int accepted_items = 0;
    int adds_seen = 0;
    int clears_seen = 0;
    int rejects_seen = 0;
    int pairs_seen = 0;
    int deepest_store = 0;
    int results_checked = 0;
    int failures = 0;
    int idle_cycles = 0;

    int        send_gap = 0;
    int        gap_mode_left = 0;
    bit        no_send_gaps = 1'b0;
    box_item_t offered_item;
    int        recv_hold = 0;
    int        stall_mode_left = 0;
    bit        no_recv_stalls = 1'b0;
    bit        hold_off_done = 1'b0;

    aabb_pairwise_overlap_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_min_x        (s_min_x),
        .s_min_y        (s_min_y),
        .s_min_z        (s_min_z),
        .s_max_x        (s_max_x),
        .s_max_y        (s_max_y),
        .s_max_z        (s_max_z),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_box_index    (m_box_index),
        .m_overlap_mask (m_overlap_mask),
        .m_rejected     (m_rejected)
    );

    always #(CLK_PERIOD / 2.0) aclk = ~aclk;

    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 16);
        return $urandom_range(30, 120);
    endfunction

    function automatic void predict_overlap(input box_item_t item);
        overlap_result_t res;
        res = '0;
        if (item.cmd == aabb_pkg::CMD_CLEAR) begin
            stored_boxes = 0;
            clears_seen++;
            return;
        end
        adds_seen++;
        if (stored_boxes >= aabb_pkg::MAX_BOXES) begin
            res.rejected = 1'b1;
            rejects_seen++;
        end else begin
            for (int i = 0; i < stored_boxes; i++) begin
                if (lower_x[i] < item.box.max_x && upper_x[i] > item.box.min_x &&
                    lower_y[i] < item.box.max_y && upper_y[i] > item.box.min_y &&
                    lower_z[i] < item.box.max_z && upper_z[i] > item.box.min_z) begin
                    res.overlap_mask[i] = 1'b1;
                end
            end
            lower_x[stored_boxes] = item.box.min_x;
            lower_y[stored_boxes] = item.box.min_y;
            lower_z[stored_boxes] = item.box.min_z;
            upper_x[stored_boxes] = item.box.max_x;
            upper_y[stored_boxes] = item.box.max_y;
            upper_z[stored_boxes] = item.box.max_z;
            res.box_index = stored_boxes[aabb_pkg::IDX_W-1:0];
            pairs_seen += $countones(res.overlap_mask);
            stored_boxes++;
            if (stored_boxes > deepest_store) deepest_store = stored_boxes;
        end
        expected_overlaps.insert(expected_overlaps.size(), res);
    endfunction

    function automatic void queue_add(input logic signed [aabb_pkg::COORD_W-1:0] lx, ly, lz,
                                      input logic signed [aabb_pkg::COORD_W-1:0] hx, hy, hz);
        box_item_t item;
        item.cmd = aabb_pkg::CMD_ADD;
        item.box = '{min_x: lx, min_y: ly, min_z: lz, max_x: hx, max_y: hy, max_z: hz};
        boxes_to_send.insert(boxes_to_send.size(), item);
    endfunction

    function automatic void queue_clear();
        box_item_t item;
        item.cmd = aabb_pkg::CMD_CLEAR;
        item.box = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        boxes_to_send.insert(boxes_to_send.size(), item);
    endfunction

    function automatic logic signed [aabb_pkg::COORD_W-1:0] extreme_coord();
        case ($urandom_range(0, 4))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return 32'sh0000_0000;
            3: return -32'sd1;
            default: return 32'sd1;
        endcase
    endfunction

    function automatic void queue_random_add();
        logic signed [aabb_pkg::COORD_W-1:0] lo[3];
        logic signed [aabb_pkg::COORD_W-1:0] hi[3];
        logic signed [aabb_pkg::COORD_W-1:0] swap;
        int kind;
        int flip_axis;
        kind = $urandom_range(0, 99);
        flip_axis = $urandom_range(0, 2);
        for (int a = 0; a < 3; a++) begin
            if (kind < 85) begin
                lo[a] = (int'($urandom_range(0, 7)) - 4) * Q_ONE;
                hi[a] = lo[a] + int'($urandom_range(0, 5)) * Q_ONE;
                if ($urandom_range(0, 3) == 0) lo[a] = lo[a] + int'($urandom_range(0, Q_ONE - 1));
                if ($urandom_range(0, 3) == 0) hi[a] = hi[a] + int'($urandom_range(0, Q_ONE - 1));
                if (kind >= 75 && a == flip_axis) begin
                    swap = lo[a];
                    lo[a] = hi[a];
                    hi[a] = swap;
                end
            end else if (kind < 95) begin
                lo[a] = $urandom;
                hi[a] = $urandom;
            end else begin
                lo[a] = extreme_coord();
                hi[a] = extreme_coord();
            end
        end
        queue_add(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
    endfunction

    function automatic void build_stimulus();
        int seq_len;
        int r;
        // Directed part: extreme corners, touching faces, degenerate and inverted boxes.
        queue_add(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                  32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        queue_add(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                  32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        queue_add(0, 0, 0, Q_ONE, Q_ONE, Q_ONE);
        queue_add(Q_ONE, 0, 0, 2 * Q_ONE, Q_ONE, Q_ONE);
        queue_add(Q_ONE / 2, Q_ONE / 2, Q_ONE / 2, 3 * Q_ONE / 2, 3 * Q_ONE / 2, 3 * Q_ONE / 2);
        queue_add(Q_ONE, 0, 0, 0, Q_ONE, Q_ONE);
        queue_add(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                  32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        queue_add(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                  32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        queue_add(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                  32'sh8000_0001, 32'sh8000_0001, 32'sh8000_0001);
        queue_add(32'shAAAA_AAAA, 32'shAAAA_AAAA, 32'shAAAA_AAAA,
                  32'sh5555_5555, 32'sh5555_5555, 32'sh5555_5555);
        queue_add(32'sh5555_5555, 32'sh5555_5555, 32'sh5555_5555,
                  32'shAAAA_AAAA, 32'shAAAA_AAAA, 32'shAAAA_AAAA);
        queue_add(-1, -1, -1, 1, 1, 1);
        queue_clear();
        queue_add(0, 0, 0, Q_ONE, Q_ONE, Q_ONE);
        queue_add(0, 0, 0, Q_ONE, Q_ONE, Q_ONE);
        queue_clear();
        queue_clear();
        queue_add(-Q_ONE, -Q_ONE, -Q_ONE, Q_ONE, Q_ONE, Q_ONE);
        queue_add(-Q_ONE, Q_ONE, -Q_ONE, Q_ONE, 2 * Q_ONE, Q_ONE);

        // The first random sequence always overfills the store.
        queue_clear();
        for (int i = 0; i < aabb_pkg::MAX_BOXES + 3; i++) queue_random_add();

        while (boxes_to_send.size() < TARGET_ITEMS) begin
            if ($urandom_range(0, 99) < 85) queue_clear();
            r = $urandom_range(0, 99);
            if (r < 65) seq_len = $urandom_range(1, 10);
            else if (r < 90) seq_len = $urandom_range(11, 40);
            else seq_len = aabb_pkg::MAX_BOXES + $urandom_range(0, 5);
            for (int i = 0; i < seq_len; i++) begin
                if ($urandom_range(0, 99) < 3) queue_clear();
                queue_random_add();
            end
        end
        total_items = boxes_to_send.size();
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                predict_overlap(offered_item);
                accepted_items++;
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (boxes_to_send.size() > 0) begin
                    offered_item = boxes_to_send.pop_front();
                    s_cmd   <= offered_item.cmd;
                    s_min_x <= offered_item.box.min_x;
                    s_min_y <= offered_item.box.min_y;
                    s_min_z <= offered_item.box.min_z;
                    s_max_x <= offered_item.box.max_x;
                    s_max_y <= offered_item.box.max_y;
                    s_max_z <= offered_item.box.max_z;
                    s_valid <= 1'b1;
                    if (gap_mode_left == 0) begin
                        no_send_gaps = ($urandom_range(0, 3) == 0);
                        gap_mode_left = $urandom_range(20, 120);
                    end
                    gap_mode_left--;
                    send_gap = no_send_gaps ? 0 : random_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        overlap_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_checked++;
                if (expected_overlaps.size() == 0) begin
                    $error("unexpected result transfer: box_index %0d mask %h rejected %0b",
                           m_box_index, m_overlap_mask, m_rejected);
                    failures++;
                end else begin
                    want = expected_overlaps.pop_front();
                    if (m_box_index !== want.box_index) begin
                        $error("box_index: expected %0d, actual %0d", want.box_index, m_box_index);
                        failures++;
                    end
                    if (m_overlap_mask !== want.overlap_mask) begin
                        $error("overlap_mask: expected %h, actual %h",
                               want.overlap_mask, m_overlap_mask);
                        failures++;
                    end
                    if (m_rejected !== want.rejected) begin
                        $error("rejected: expected %0b, actual %0b", want.rejected, m_rejected);
                        failures++;
                    end
                end
                // One long hold-off lets the core fill up and push back on its input.
                if (!hold_off_done && results_checked == HOLD_OFF_AT) begin
                    recv_hold = HOLD_OFF_CYCLES;
                    hold_off_done = 1'b1;
                end
            end
            if (recv_hold == 0) begin
                if (stall_mode_left == 0) begin
                    no_recv_stalls = ($urandom_range(0, 3) == 0);
                    stall_mode_left = $urandom_range(50, 400);
                end
                stall_mode_left--;
                if (!no_recv_stalls && $urandom_range(0, 99) < 15) recv_hold = random_gap() + 1;
            end
            if (recv_hold > 0) begin
                recv_hold--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles, %0d of %0d items accepted.",
                     WATCHDOG_LIMIT, accepted_items, total_items);
            $display("aabb_pairwise_overlap_core test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        build_stimulus();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        while (accepted_items < total_items) @(posedge aclk);
        while (expected_overlaps.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Covered %0d adds (%0d rejected on a full store) and %0d clears,",
                 adds_seen, rejects_seen, clears_seen);
        $display("%0d results checked, %0d overlapping pairs, store held up to %0d boxes.",
                 results_checked, pairs_seen, deepest_store);
        if (failures == 0) begin
            $display("aabb_pairwise_overlap_core test passed");
        end else begin
            $display("aabb_pairwise_overlap_core test failed");
        end
        $finish;
    end

endmodule
